### rtl/core/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the signed decimal field formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int MAX_CHARS   = 64;
    localparam int BIN_W       = 64;
    localparam int DIGITS      = 20;
    localparam int BCD_W       = 4 * DIGITS;
    localparam int CNT_W       = $clog2(MAX_CHARS + 1);
    localparam int NDIG_W      = $clog2(DIGITS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NONE  = 8'h00;

    localparam logic REG_MIN_DIGITS = 1'b0;

    typedef struct packed {
        logic [BIN_W-1:0] mag;
        logic [7:0]       sign;
        logic             has_sign;
        logic [5:0]       width;
        logic             left;
        logic             zpad;
    } t_item;

endpackage

### rtl/core/sdf_front.sv
// ----------------------------------------------------------------------------
// sdf_front
// Accepts an item, takes its magnitude and picks the sign character.
// ----------------------------------------------------------------------------
module sdf_front
    import sdf_pkg::*;
(
    input  logic             i_start,
    input  logic             i_full,
    input  logic [BIN_W-1:0] i_value,
    input  logic [5:0]       i_field_width,
    input  logic             i_force_plus,
    input  logic             i_space_sign,
    input  logic             i_left_justify,
    input  logic             i_zero_pad,
    output logic             o_push,
    output t_item            o_item
);

    logic neg;

    assign neg    = i_value[BIN_W-1];
    assign o_push = i_start && !i_full;

    always_comb begin
        o_item.mag      = neg ? (~i_value + {{(BIN_W-1){1'b0}}, 1'b1}) : i_value;
        o_item.width    = i_field_width;
        o_item.left     = i_left_justify;
        o_item.zpad     = i_zero_pad;
        o_item.has_sign = neg || i_force_plus || i_space_sign;
        if (neg) begin
            o_item.sign = CH_MINUS;
        end else if (i_force_plus) begin
            o_item.sign = CH_PLUS;
        end else if (i_space_sign) begin
            o_item.sign = CH_SPACE;
        end else begin
            o_item.sign = CH_NONE;
        end
    end

endmodule

### rtl/core/sdf_queue.sv
// ----------------------------------------------------------------------------
// sdf_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module sdf_queue
    import sdf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'(QUEUE_DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/sdf_back.sv
// ----------------------------------------------------------------------------
// sdf_back
// Converts the magnitude to decimal by shift-and-add-3, strips leading
// zero digits, lays out the field and emits it one character per cycle.
// ----------------------------------------------------------------------------
module sdf_back
    import sdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    input  logic [6:0] i_min_digits,
    output logic       o_pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]       r_state,   n_state;
    logic [BIN_W-1:0] r_bin,     n_bin;
    logic [BCD_W-1:0] r_bcd,     n_bcd;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [NDIG_W-1:0] r_ndig,   n_ndig;
    logic [7:0]       r_sign,    n_sign;
    logic             r_has_sign, n_has_sign;
    logic [5:0]       r_width,   n_width;
    logic             r_left,    n_left;
    logic             r_zpad,    n_zpad;
    logic [5:0]       r_pre,     n_pre;
    logic [6:0]       r_zeros,   n_zeros;
    logic [5:0]       r_post,    n_post;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char,  n_out_char;
    logic             r_last_char, n_last_char;

    logic [BCD_W-1:0] bcd_adj;
    logic [6:0]       prec;
    logic [6:0]       ndig7;
    logic [6:0]       digits;
    logic [6:0]       body;
    logic [6:0]       width7;
    logic [5:0]       pad;
    logic [6:0]       lead;

    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                bcd_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                bcd_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        prec   = i_min_digits[6] ? 7'd0 : i_min_digits;
        ndig7  = {{(7-NDIG_W){1'b0}}, r_ndig};
        digits = (prec > ndig7) ? prec : ndig7;
        body   = digits + {6'd0, r_has_sign};
        width7 = {1'b0, r_width};
        pad    = (width7 > body) ? 6'(width7 - body) : 6'd0;
        lead   = digits - ndig7;
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_ndig      = r_ndig;
        n_sign      = r_sign;
        n_has_sign  = r_has_sign;
        n_width     = r_width;
        n_left      = r_left;
        n_zpad      = r_zpad;
        n_pre       = r_pre;
        n_zeros     = r_zeros;
        n_post      = r_post;
        n_out_valid = 1'b0;
        n_out_char  = r_out_char;
        n_last_char = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop      = 1'b1;
                    n_bin      = i_item.mag;
                    n_bcd      = '0;
                    n_cnt      = '0;
                    n_sign     = i_item.sign;
                    n_has_sign = i_item.has_sign;
                    n_width    = i_item.width;
                    n_left     = i_item.left;
                    n_zpad     = i_item.zpad;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                {n_bcd, n_bin} = {bcd_adj, r_bin} << 1;
                n_cnt = r_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
                if (r_cnt == CNT_W'(BIN_W - 1)) begin
                    n_ndig  = NDIG_W'(DIGITS);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_bcd[BCD_W-1 -: 4] == 4'd0 && r_ndig > NDIG_W'(1)) begin
                    n_bcd  = r_bcd << 4;
                    n_ndig = r_ndig - NDIG_W'(1);
                end else begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_pre   = (!r_left && !r_zpad) ? pad : 6'd0;
                n_zeros = ((!r_left && r_zpad) ? {1'b0, pad} : 7'd0) + lead;
                n_post  = r_left ? pad : 6'd0;
                n_cnt   = CNT_W'(body + {1'b0, pad});
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_out_valid = 1'b1;
                n_last_char = (r_cnt == CNT_W'(1));
                n_cnt       = r_cnt - CNT_W'(1);
                if (r_pre != 6'd0) begin
                    n_out_char = CH_SPACE;
                    n_pre      = r_pre - 6'd1;
                end else if (r_has_sign) begin
                    n_out_char = r_sign;
                    n_has_sign = 1'b0;
                end else if (r_zeros != 7'd0) begin
                    n_out_char = CH_ZERO;
                    n_zeros    = r_zeros - 7'd1;
                end else if (r_ndig != '0) begin
                    n_out_char = CH_ZERO + {4'd0, r_bcd[BCD_W-1 -: 4]};
                    n_bcd      = r_bcd << 4;
                    n_ndig     = r_ndig - NDIG_W'(1);
                end else begin
                    n_out_char = CH_SPACE;
                    n_post     = r_post - 6'd1;
                end
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_last_char <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last_char <= n_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_ndig     <= n_ndig;
        r_sign     <= n_sign;
        r_has_sign <= n_has_sign;
        r_width    <= n_width;
        r_left     <= n_left;
        r_zpad     <= n_zpad;
        r_pre      <= n_pre;
        r_zeros    <= n_zeros;
        r_post     <= n_post;
        r_out_char <= n_out_char;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_last_char;

endmodule

### rtl/core/signed_decimal_field_formatter_core.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_core
// Formats a signed 64-bit value as printf-style decimal text, one character
// per output strobe, with width, sign, justify and zero-pad options.
// ----------------------------------------------------------------------------
// channel  direction  transfer when                      payload
// input    in         i_start && !o_busy                 i_value, i_field_width, flags
// output   out        o_out_valid (one cycle, no stall)  o_out_char, o_last_char
// config   in         psel && penable && pwrite          pwdata -> min_digits at 0x0
//
// An item is loaded, converted by shift-and-add-3 over its 64 bits, stripped
// of up to 19 leading zero digits and set up; then one character per cycle
// is emitted, 1 to 64 characters in all.
// Two items can wait in the queue; o_busy rises when it is full.
// Reset is synchronous; min_digits resets to -1. The receiver cannot stall.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_core
    import sdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_field_width,
    input  logic        i_force_plus,
    input  logic        i_space_sign,
    input  logic        i_left_justify,
    input  logic        i_zero_pad,
    output logic        o_out_valid,
    output logic [7:0]  o_out_char,
    output logic        o_last_char,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] r_min_digits;
    logic       full;
    logic       push;
    t_item      front_item;
    logic       q_valid;
    t_item      q_item;
    logic       pop;

    assign pready = 1'b1;
    assign o_busy = full;
    assign prdata = (paddr[2] == REG_MIN_DIGITS) ? {{25{r_min_digits[6]}}, r_min_digits}
                                                 : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_digits <= 7'h7F;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_DIGITS) begin
            r_min_digits <= pwdata[6:0];
        end
    end

    sdf_front u_front (
        .i_start        (i_start),
        .i_full         (full),
        .i_value        (i_value),
        .i_field_width  (i_field_width),
        .i_force_plus   (i_force_plus),
        .i_space_sign   (i_space_sign),
        .i_left_justify (i_left_justify),
        .i_zero_pad     (i_zero_pad),
        .o_push         (push),
        .o_item         (front_item)
    );

    sdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    sdf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .i_min_digits (r_min_digits),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

endmodule

### rtl/core/sdf_checker.sv
// ----------------------------------------------------------------------------
// sdf_assertions
// Port-level checks of the formatter core, bound to the top level.
// ----------------------------------------------------------------------------
module sdf_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_out_valid,
    input logic        o_last_char
);

    a_last_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_char |-> o_out_valid)
        else $error("last marker without a character");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("character right after reset");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_char) |=> !o_out_valid)
        else $error("field followed without a gap");

    a_field_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_char) |=> o_out_valid)
        else $error("field broken before its last character");

    a_busy_needs_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !i_start) |=> !o_busy)
        else $error("busy without a transfer");

endmodule

bind signed_decimal_field_formatter_core sdf_assertions u_sdf_assertions (.*);

### sim/sdf_checker.sv
// ----------------------------------------------------------------------------
// sdf_checker
// Watches the item, character and register channels of the formatter,
// builds the expected field text for every accepted item and compares each
// emitted character and its last flag against it, in order.
// ----------------------------------------------------------------------------
module sdf_checker
    import sdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_field_width,
    input  logic        i_force_plus,
    input  logic        i_space_sign,
    input  logic        i_left_justify,
    input  logic        i_zero_pad,
    input  logic        i_out_valid,
    input  logic [7:0]  i_out_char,
    input  logic        i_last_char,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_pending,
    output int          o_fail_count
);

    localparam logic [2:0] ADDR_MIN_DIGITS = {REG_MIN_DIGITS, 2'b00};
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_field_char;

    t_field_char field_chars[$];
    logic [6:0]  min_digits;
    int          fail_count;

    assign o_fail_count = fail_count;

    function automatic void predict_field(
        input logic [63:0] value,
        input logic [5:0]  width,
        input logic        plus,
        input logic        space,
        input logic        left,
        input logic        zpad,
        input logic [6:0]  prec_reg
    );
        logic [63:0] mag;
        logic [3:0]  dig[DIGITS];
        logic [7:0]  sgn;
        logic [7:0]  text[$];
        int          ndig;
        int          prec;
        int          ndigits;
        int          signlen;
        int          body;
        int          pad;
        int          total;
        int          pos;
        t_field_char fc;
        mag  = value[63] ? (64'd0 - value) : value;
        ndig = 0;
        do begin
            dig[ndig] = 4'(mag % 64'd10);
            mag = mag / 64'd10;
            ndig++;
        end while (mag != 0 && ndig < DIGITS);
        prec    = prec_reg[6] ? 0 : int'(prec_reg);
        ndigits = (prec > ndig) ? prec : ndig;
        if (ndigits > MAX_CHARS - 1) ndigits = MAX_CHARS - 1;
        if (value[63]) sgn = CH_MINUS;
        else if (plus) sgn = CH_PLUS;
        else if (space) sgn = CH_SPACE;
        else sgn = CH_NONE;
        signlen = (sgn != CH_NONE) ? 1 : 0;
        body    = signlen + ndigits;
        pad     = (int'(width) > body) ? int'(width) - body : 0;
        total   = body + pad;
        if (total > MAX_CHARS) begin
            total = MAX_CHARS;
            pad   = total - body;
        end
        if (!left && !zpad) repeat (pad) text.push_back(CH_SPACE);
        if (signlen != 0) text.push_back(sgn);
        if (!left && zpad) repeat (pad) text.push_back(CH_ZERO);
        for (int i = 0; i < ndigits; i++) begin
            pos = ndigits - 1 - i;
            text.push_back((pos < ndig) ? (CH_ZERO + 8'(dig[pos])) : CH_ZERO);
        end
        if (left) repeat (pad) text.push_back(CH_SPACE);
        for (int i = 0; i < total; i++) begin
            fc.ch   = text[i];
            fc.last = (i == total - 1);
            field_chars.push_back(fc);
        end
    endfunction

    always @(posedge i_clk) begin
        t_field_char want;
        if (!i_rst_n) begin
            field_chars.delete();
            min_digits <= 7'h7F;
            fail_count <= 0;
            o_pending  <= 0;
        end else begin
            if (i_out_valid) begin
                if (field_chars.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected char 0x%02h last=%0b", i_out_char, i_last_char);
                    fail_count <= fail_count + 1;
                end else begin
                    want = field_chars.pop_front();
                    if (want.ch !== i_out_char || want.last !== i_last_char) begin
                        if (fail_count < REPORT_MAX)
                            $display("char mismatch: exp 0x%02h last=%0b got 0x%02h last=%0b",
                                     want.ch, want.last, i_out_char, i_last_char);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                predict_field(i_value, i_field_width, i_force_plus, i_space_sign,
                              i_left_justify, i_zero_pad, min_digits);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_MIN_DIGITS)
                min_digits <= i_pwdata[6:0];
            o_pending <= field_chars.size();
        end
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the formatter with directed and random values, widths and flags
// under several minimum digit settings, with random gaps on the item side,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import sdf_pkg::*;

    localparam logic [2:0] ADDR_MIN_DIGITS = {REG_MIN_DIGITS, 2'b00};
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int PHASE_ITEMS  = 37;
    localparam int DRAIN_CYCLES = 160;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [63:0] i_value;
    logic [5:0]  i_field_width;
    logic        i_force_plus;
    logic        i_space_sign;
    logic        i_left_justify;
    logic        i_zero_pad;
    logic        o_out_valid;
    logic [7:0]  o_out_char;
    logic        o_last_char;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic        in_xfer;
    logic        calm;
    int          pending;
    int          fail_count;
    int          cycles = 0;

    signed_decimal_field_formatter_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_value        (i_value),
        .i_field_width  (i_field_width),
        .i_force_plus   (i_force_plus),
        .i_space_sign   (i_space_sign),
        .i_left_justify (i_left_justify),
        .i_zero_pad     (i_zero_pad),
        .o_out_valid    (o_out_valid),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    sdf_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_value        (i_value),
        .i_field_width  (i_field_width),
        .i_force_plus   (i_force_plus),
        .i_space_sign   (i_space_sign),
        .i_left_justify (i_left_justify),
        .i_zero_pad     (i_zero_pad),
        .i_out_valid    (o_out_valid),
        .i_out_char     (o_out_char),
        .i_last_char    (o_last_char),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) in_xfer <= i_rst_n && i_start && !o_busy;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [63:0] v, input logic [5:0] w,
                             input logic p, input logic s, input logic l, input logic z);
        i_value        <= v;
        i_field_width  <= w;
        i_force_plus   <= p;
        i_space_sign   <= s;
        i_left_justify <= l;
        i_zero_pad     <= z;
        i_start        <= 1'b1;
        do @(negedge i_clk); while (!in_xfer);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_min_digits(input int n);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MIN_DIGITS;
        pwdata  <= 32'(n);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          k;
        case ($urandom_range(0, 5))
            0, 1: v = {$urandom(), $urandom()};
            2: v = 64'($urandom_range(0, 999));
            3: v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            4: begin
                case ($urandom_range(0, 4))
                    0: v = 64'd0;
                    1: v = 64'h8000_0000_0000_0000;
                    2: v = 64'h7FFF_FFFF_FFFF_FFFF;
                    3: v = 64'd1;
                    default: v = '1;
                endcase
            end
            default: begin
                v = 64'd1;
                k = $urandom_range(0, 18);
                repeat (k) v = v * 64'd10;
                v = v - 64'($urandom_range(0, 1));
            end
        endcase
        if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
        return v;
    endfunction

    task automatic send_random();
        logic [5:0] w;
        logic [3:0] f;
        w = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 24));
        f = 4'($urandom());
        send_item(pick_value(), w, f[0], f[1], f[2], f[3]);
    endtask

    initial begin
        int settings[10];
        settings = '{-1, 0, 1, 3, 19, 20, 62, -64, -2, 7};
        calm           = 1'b0;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_value        = '0;
        i_field_width  = '0;
        i_force_plus   = 1'b0;
        i_space_sign   = 1'b0;
        i_left_justify = 1'b0;
        i_zero_pad     = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(64'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item('1, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_item(64'h8000_0000_0000_0000, 6'd0, 1'b1, 1'b1, 1'b0, 1'b0);
        send_item(64'd12345, 6'd10, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(64'd12345, 6'd10, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(64'd12345, 6'd10, 1'b0, 1'b0, 1'b1, 1'b0);
        send_item(64'd12345, 6'd10, 1'b0, 1'b0, 1'b1, 1'b1);
        send_item(64'd42, 6'd6, 1'b1, 1'b0, 1'b0, 1'b1);
        send_item(64'd42, 6'd6, 1'b0, 1'b1, 1'b0, 1'b0);
        send_item(64'd42, 6'd6, 1'b0, 1'b1, 1'b1, 1'b0);
        send_item(64'd0 - 64'd42, 6'd6, 1'b1, 1'b1, 1'b0, 1'b1);
        send_item(64'd0, 6'd63, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(64'h8000_0000_0000_0000, 6'd63, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(64'h8000_0000_0000_0000, 6'd63, 1'b0, 1'b0, 1'b1, 1'b0);
        send_item(64'd9, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0);
        drain();
        set_min_digits(0);
        send_item(64'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(64'd0, 6'd3, 1'b1, 1'b0, 1'b0, 1'b1);
        drain();
        set_min_digits(62);
        send_item(64'd0 - 64'd7, 6'd63, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(64'd7, 6'd63, 1'b1, 1'b0, 1'b1, 1'b0);
        send_item(64'h8000_0000_0000_0000, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        drain();
        set_min_digits(5);
        send_item(64'd123, 6'd9, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(64'd123, 6'd9, 1'b0, 1'b1, 1'b1, 1'b0);
        drain();

        foreach (settings[ph]) begin
            set_min_digits(settings[ph]);
            calm = (ph == 9);
            repeat (PHASE_ITEMS) send_random();
            drain();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
